/* rtl/dfr_pkg.sv */
`default_nettype none

package dfr_pkg;

  localparam int BUF_SIZE = 128;
  localparam int IDX_W = $clog2(BUF_SIZE);

  localparam logic [7:0] CH_CMD    = 8'h24;  // '$'
  localparam logic [7:0] CH_SINGLE = 8'h23;  // '#'
  localparam logic [7:0] CH_MULTI  = 8'h7B;  // '{'
  localparam logic [7:0] CH_STORE  = 8'h3C;  // '<'
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'

  typedef enum logic [1:0] {
    FN_BYTE    = 2'd0,
    FN_RELEASE = 2'd1,
    FN_READ    = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_CMD    = 3'd1,
    MODE_SINGLE = 3'd2,
    MODE_MULTI  = 3'd3,
    MODE_STORE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CL_NONE  = 2'd0,
    CL_BANG  = 2'd1,
    CL_BRACE = 2'd2,
    CL_GT    = 2'd3
  } closer_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  rx_byte;
    logic [2:0]  source;
    logic [6:0]  read_index;
    mode_t       start_mode;
    closer_t     closer;
  } item_t;

endpackage

`default_nettype wire

/* rtl/dfr_front.sv */
`default_nettype none

module dfr_front (
  input  wire logic [1:0]   func,
  input  wire logic [7:0]   rx_byte,
  input  wire logic [2:0]   source_port,
  input  wire logic [6:0]   read_index,
  output dfr_pkg::item_t    item
);

  always_comb begin
    item.func       = dfr_pkg::func_t'(func);
    item.rx_byte    = rx_byte;
    item.source     = source_port;
    item.read_index = read_index;

    unique case (rx_byte)
      dfr_pkg::CH_CMD:    item.start_mode = dfr_pkg::MODE_CMD;
      dfr_pkg::CH_SINGLE: item.start_mode = dfr_pkg::MODE_SINGLE;
      dfr_pkg::CH_MULTI:  item.start_mode = dfr_pkg::MODE_MULTI;
      dfr_pkg::CH_STORE:  item.start_mode = dfr_pkg::MODE_STORE;
      default:            item.start_mode = dfr_pkg::MODE_IDLE;
    endcase

    unique case (rx_byte)
      dfr_pkg::CH_BANG:   item.closer = dfr_pkg::CL_BANG;
      dfr_pkg::CH_RBRACE: item.closer = dfr_pkg::CL_BRACE;
      dfr_pkg::CH_GT:     item.closer = dfr_pkg::CL_GT;
      default:            item.closer = dfr_pkg::CL_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dfr_queue.sv */
`default_nettype none

module dfr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_stall,
  input  wire dfr_pkg::item_t   push_item,
  output logic                  pop_valid,
  input  wire logic             pop_stall,
  output dfr_pkg::item_t        pop_item
);

  dfr_pkg::item_t slot [2];
  logic           rd_ptr;
  logic           wr_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slot[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_item;
  end

endmodule

`default_nettype wire

/* rtl/dfr_back.sv */
`default_nettype none

module dfr_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_stall,
  input  wire dfr_pkg::item_t   q_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  byte_stored,
  output logic                  busy_dropped,
  output logic                  frame_done,
  output logic [2:0]            frame_mode,
  output logic [6:0]            frame_length,
  output logic [2:0]            frame_source,
  output logic [7:0]            read_byte
);

  localparam int IW = dfr_pkg::IDX_W;

  logic [7:0]         mem [dfr_pkg::BUF_SIZE];

  dfr_pkg::mode_t     mode;
  dfr_pkg::mode_t     mode_next;
  logic               ready;
  logic               ready_next;
  logic [IW-1:0]      widx;
  logic [IW-1:0]      widx_next;
  logic [2:0]         src;
  logic [2:0]         src_next;

  // zero terminator waiting for a free write cycle
  logic               pend;
  logic [IW-1:0]      term_addr;

  logic               take;
  logic               is_byte;
  logic               busy;
  dfr_pkg::mode_t     eff_mode;
  logic               active;
  logic [IW-1:0]      widx_base;
  logic [IW-1:0]      widx_after;
  logic               store;
  logic               match;
  logic               closes;
  logic               rd_ok;
  logic [IW-1:0]      rd_addr;

  assign q_stall = out_valid && out_stall;
  assign take    = q_valid && !q_stall;

  // decisions shared by state update and result flags
  always_comb begin
    is_byte   = (q_item.func == dfr_pkg::FN_BYTE);
    busy      = is_byte && ready;
    eff_mode  = (mode == dfr_pkg::MODE_IDLE) ? q_item.start_mode : mode;
    active    = is_byte && !ready && (eff_mode != dfr_pkg::MODE_IDLE);
    widx_base = (mode == dfr_pkg::MODE_IDLE) ? '0 : widx;
    store     = active && (widx_base < IW'(dfr_pkg::BUF_SIZE - 1));
    widx_after = store ? widx_base + IW'(1) : widx_base;
    unique case (q_item.closer)
      dfr_pkg::CL_BANG:  match = (eff_mode == dfr_pkg::MODE_CMD) ||
                                 (eff_mode == dfr_pkg::MODE_SINGLE);
      dfr_pkg::CL_BRACE: match = (eff_mode == dfr_pkg::MODE_MULTI);
      dfr_pkg::CL_GT:    match = (eff_mode == dfr_pkg::MODE_STORE);
      default:           match = 1'b0;
    endcase
    closes  = active && match;
    rd_ok   = (q_item.func == dfr_pkg::FN_READ) &&
              (32'(q_item.read_index) < dfr_pkg::BUF_SIZE);
    rd_addr = IW'(q_item.read_index);
  end

  // next state
  always_comb begin
    mode_next  = mode;
    ready_next = ready;
    widx_next  = widx;
    src_next   = src;
    if (q_item.func == dfr_pkg::FN_RELEASE) begin
      mode_next  = dfr_pkg::MODE_IDLE;
      ready_next = 1'b0;
    end else if (active) begin
      mode_next = eff_mode;
      widx_next = widx_after;
      if (closes) begin
        ready_next = 1'b1;
        src_next   = q_item.source;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= dfr_pkg::MODE_IDLE;
      ready     <= 1'b0;
      widx      <= '0;
      src       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        mode  <= mode_next;
        ready <= ready_next;
        widx  <= widx_next;
        src   <= src_next;
      end
      pend <= take && closes;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      byte_stored  <= store;
      busy_dropped <= busy;
      frame_done   <= closes;
      frame_mode   <= 3'(mode_next);
      frame_length <= 7'(widx_next);
      frame_source <= src_next;
    end
    if (take && closes) term_addr <= widx_after;
  end

  // frame buffer; the cycle after a close never stores a byte, so the
  // terminator takes the write port then
  always_ff @(posedge clk) begin
    if (pend) begin
      mem[term_addr] <= '0;
    end else if (take && store) begin
      mem[widx_base] <= q_item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!rd_ok) begin
        read_byte <= '0;
      end else if (pend && (term_addr == rd_addr)) begin
        read_byte <= '0;
      end else begin
        read_byte <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/delimited_frame_receiver.sv */
// path: an accepted item waits in the front queue; the back stage then registers its result
// throughput: one item per cycle while out_stall is low; the queue holds two items and
//   the frame buffer takes one write per cycle (a closing terminator uses the next cycle)
// reset: rst is synchronous and active high; it clears mode, ready flag, write index,
//   latched source and all handshake state; buffer contents stay undefined until written
`default_nettype none

module delimited_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [2:0]  source_port,
  input  wire logic [6:0]  read_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             byte_stored,
  output logic             busy_dropped,
  output logic             frame_done,
  output logic [2:0]       frame_mode,
  output logic [6:0]       frame_length,
  output logic [2:0]       frame_source,
  output logic [7:0]       read_byte
);

  dfr_pkg::item_t in_item;
  dfr_pkg::item_t q_item;
  logic           q_valid;
  logic           q_stall;

  dfr_front u_front (
    .func        (func),
    .rx_byte     (rx_byte),
    .source_port (source_port),
    .read_index  (read_index),
    .item        (in_item)
  );

  dfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item)
  );

  dfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_stall      (q_stall),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_stored  (byte_stored),
    .busy_dropped (busy_dropped),
    .frame_done   (frame_done),
    .frame_mode   (frame_mode),
    .frame_length (frame_length),
    .frame_source (frame_source),
    .read_byte    (read_byte)
  );

`ifndef SYNTHESIS
  a_done_has_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> frame_mode != 3'(dfr_pkg::MODE_IDLE))
    else $error("closed frame reported with idle mode");

  a_busy_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && busy_dropped |-> !byte_stored && !frame_done)
    else $error("refused beat also stored or closed a frame");

  a_stall_means_queued: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("input stalled with empty queue");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    q_valid && !out_valid |=> out_valid)
    else $error("queued beat not executed with free output");
`endif

endmodule

`default_nettype wire

/* tb/delimited_frame_receiver_test.sv */
`timescale 1ns / 100ps

module delimited_frame_receiver_test;

  typedef struct packed {
    logic            stored;
    logic            busy;
    logic            done;
    dfr_pkg::mode_t  mode;
    logic [6:0]      len;
    logic [2:0]      src;
    logic [7:0]      rd;
  } frame_result_t;

  class frame_scoreboard;
    dfr_pkg::mode_t mode;
    bit             ready;
    int unsigned    wr_idx;
    logic [2:0]     src;
    logic [7:0]     mem [dfr_pkg::BUF_SIZE];
    int             hi_written;
    int             useful_items;
    int             errors;
    frame_result_t  expected_q [$];

    function new();
      mode = dfr_pkg::MODE_IDLE;
      ready = 0;
      wr_idx = 0;
      src = '0;
      hi_written = -1;
      useful_items = 0;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    // entries are always written in order from 0, so the written set is 0..hi_written
    function void note_item(dfr_pkg::func_t f, logic [7:0] b, logic [2:0] port,
                            logic [6:0] ridx);
      frame_result_t  r;
      dfr_pkg::mode_t m;
      bit             active;
      r = '0;
      active = 0;
      case (f)
        dfr_pkg::FN_BYTE: begin
          if (ready) begin
            r.busy = 1;
          end else begin
            active = 1;
            if (mode == dfr_pkg::MODE_IDLE) begin
              case (b)
                dfr_pkg::CH_CMD:    m = dfr_pkg::MODE_CMD;
                dfr_pkg::CH_SINGLE: m = dfr_pkg::MODE_SINGLE;
                dfr_pkg::CH_MULTI:  m = dfr_pkg::MODE_MULTI;
                dfr_pkg::CH_STORE:  m = dfr_pkg::MODE_STORE;
                default:            m = dfr_pkg::MODE_IDLE;
              endcase
              if (m == dfr_pkg::MODE_IDLE) begin
                active = 0;
              end else begin
                wr_idx = 0;
                mode = m;
              end
            end
            if (active) begin
              if (wr_idx < dfr_pkg::BUF_SIZE - 1) begin
                mem[wr_idx] = b;
                if (int'(wr_idx) > hi_written) hi_written = wr_idx;
                wr_idx++;
                r.stored = 1;
              end
              if (((mode == dfr_pkg::MODE_CMD || mode == dfr_pkg::MODE_SINGLE) &&
                   b == dfr_pkg::CH_BANG) ||
                  (mode == dfr_pkg::MODE_MULTI && b == dfr_pkg::CH_RBRACE) ||
                  (mode == dfr_pkg::MODE_STORE && b == dfr_pkg::CH_GT)) begin
                // terminator still lands when the buffer is full
                if (wr_idx < dfr_pkg::BUF_SIZE) begin
                  mem[wr_idx] = 8'h00;
                  if (int'(wr_idx) > hi_written) hi_written = wr_idx;
                end
                ready = 1;
                src = port;
                r.done = 1;
              end
            end
          end
        end
        dfr_pkg::FN_RELEASE: begin
          ready = 0;
          mode = dfr_pkg::MODE_IDLE;
        end
        dfr_pkg::FN_READ: begin
          if (ridx < dfr_pkg::BUF_SIZE) r.rd = mem[ridx];
        end
        default: ;
      endcase
      if (!(f == dfr_pkg::FN_NONE || (f == dfr_pkg::FN_BYTE && !ready && !active && !r.done)))
        useful_items++;
      r.mode = mode;
      r.len = 7'(wr_idx);
      r.src = src;
      expected_q.push_back(r);
    endfunction

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(logic stored, logic busy, logic done, logic [2:0] fmode,
                      logic [6:0] len, logic [2:0] fsrc, logic [7:0] rd);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      cmp_field("byte_stored", 8'(stored), 8'(want.stored));
      cmp_field("busy_dropped", 8'(busy), 8'(want.busy));
      cmp_field("frame_done", 8'(done), 8'(want.done));
      cmp_field("frame_mode", 8'(fmode), 8'(want.mode));
      cmp_field("frame_length", 8'(len), 8'(want.len));
      cmp_field("frame_source", 8'(fsrc), 8'(want.src));
      cmp_field("read_byte", rd, want.rd);
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] func;
  logic [7:0] rx_byte;
  logic [2:0] source_port;
  logic [6:0] read_index;
  logic       out_valid;
  logic       out_stall;
  logic       byte_stored;
  logic       busy_dropped;
  logic       frame_done;
  logic [2:0] frame_mode;
  logic [6:0] frame_length;
  logic [2:0] frame_source;
  logic [7:0] read_byte;

  frame_scoreboard sb;
  bit in_taken;
  int beats_taken;
  int burst_left;
  bit holdoff_done;

  localparam int HOLDOFF_CYCLES = 80;

  delimited_frame_receiver i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .rx_byte      (rx_byte),
    .source_port  (source_port),
    .read_index   (read_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_stored  (byte_stored),
    .busy_dropped (busy_dropped),
    .frame_done   (frame_done),
    .frame_mode   (frame_mode),
    .frame_length (frame_length),
    .frame_source (frame_source),
    .read_byte    (read_byte)
  );

  always #10 clk = ~clk;

  // pre-edge values are read here, before the block's updates land
  always @(posedge clk) begin
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) begin
      sb.note_item(dfr_pkg::func_t'(func), rx_byte, source_port, read_index);
      beats_taken++;
    end
    if (!rst && out_valid && !out_stall)
      sb.check_result(byte_stored, busy_dropped, frame_done, frame_mode,
                      frame_length, frame_source, read_byte);
  end

  task automatic send_beat(dfr_pkg::func_t f, logic [7:0] b, logic [2:0] p, logic [6:0] ri);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    rx_byte <= b;
    source_port <= p;
    read_index <= ri;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_beat(dfr_pkg::FN_BYTE, b, 3'($urandom_range(7, 0)), 7'($urandom_range(127, 0)));
  endtask

  task automatic send_release();
    send_beat(dfr_pkg::FN_RELEASE, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)),
              7'($urandom_range(127, 0)));
  endtask

  task automatic send_none();
    send_beat(dfr_pkg::FN_NONE, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)),
              7'($urandom_range(127, 0)));
  endtask

  // only positions already written are read
  task automatic send_read();
    if (sb.hi_written >= 0)
      send_beat(dfr_pkg::FN_READ, 8'($urandom_range(255, 0)), 3'($urandom_range(7, 0)),
                7'($urandom_range(sb.hi_written, 0)));
  endtask

  task automatic random_frame(bit close_it, bit long_body);
    logic [7:0] opener;
    logic [7:0] closer;
    logic [7:0] b;
    int         n;
    case ($urandom_range(3, 0))
      0: begin opener = dfr_pkg::CH_CMD;    closer = dfr_pkg::CH_BANG;   end
      1: begin opener = dfr_pkg::CH_SINGLE; closer = dfr_pkg::CH_BANG;   end
      2: begin opener = dfr_pkg::CH_MULTI;  closer = dfr_pkg::CH_RBRACE; end
      default: begin opener = dfr_pkg::CH_STORE; closer = dfr_pkg::CH_GT; end
    endcase
    n = long_body ? $urandom_range(140, 118) : $urandom_range(10, 0);
    send_byte(opener);
    repeat (n) begin
      b = 8'($urandom_range(255, 0));
      // an early closer now and then ends the frame short
      if (b == closer && $urandom_range(3, 0) != 0) b = 8'h55;
      send_byte(b);
    end
    if (close_it) send_byte(closer);
    repeat ($urandom_range(3, 0)) send_read();
    if ($urandom_range(4, 0) == 0) send_byte(8'($urandom_range(255, 0)));
    if ($urandom_range(9, 0) != 0) send_release();
  endtask

  // receiver stall patterns, with one long hold-off to back the block up
  initial begin
    int kind;
    int span;
    int k;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (!holdoff_done && beats_taken >= 120) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1;
      end
      kind = $urandom_range(3, 0);
      span = $urandom_range(40, 5);
      for (k = 0; k < span; k++) begin
        case (kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(2, 0) == 0);
          2: out_stall <= ($urandom_range(3, 0) != 0);
          default: out_stall <= (k % 4 == 3);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int  r;
    bit  first_long;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    func = dfr_pkg::FN_BYTE;
    rx_byte = '0;
    source_port = '0;
    read_index = '0;
    burst_left = 0;
    beats_taken = 0;
    holdoff_done = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: ignored bytes while idle, unused func, idle release
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dfr_pkg::CH_BANG);
    send_none();
    send_release();
    send_beat(dfr_pkg::FN_BYTE, dfr_pkg::CH_CMD, 3'd7, 7'd0);
    send_beat(dfr_pkg::FN_BYTE, 8'h61, 3'd0, 7'd127);
    send_beat(dfr_pkg::FN_BYTE, dfr_pkg::CH_BANG, 3'd5, 7'd0);
    send_byte(8'h78);                            // refused, frame waiting
    send_beat(dfr_pkg::FN_READ, 8'h00, 3'd0, 7'd0);
    send_beat(dfr_pkg::FN_READ, 8'hFF, 3'd7, 7'd3);       // terminator
    send_release();
    send_byte(dfr_pkg::CH_SINGLE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(dfr_pkg::CH_RBRACE);                        // not a closer in this mode
    send_beat(dfr_pkg::FN_BYTE, dfr_pkg::CH_BANG, 3'd0, 7'd0);
    send_release();
    send_byte(dfr_pkg::CH_MULTI);
    send_byte(dfr_pkg::CH_BANG);
    send_byte(dfr_pkg::CH_GT);
    send_byte(dfr_pkg::CH_CMD);                  // start byte inside a frame is data
    send_byte(dfr_pkg::CH_RBRACE);
    send_release();
    send_byte(dfr_pkg::CH_STORE);
    send_byte(dfr_pkg::CH_RBRACE);
    send_byte(dfr_pkg::CH_GT);
    send_beat(dfr_pkg::FN_READ, 8'h00, 3'd0, 7'd2);
    send_release();

    // random: mostly whole frames, some noise and broken frames
    first_long = 1;
    while (sb.useful_items < 450) begin
      r = $urandom_range(99, 0);
      if (r < 65) begin
        random_frame($urandom_range(19, 0) != 0, first_long || $urandom_range(24, 0) == 0);
        first_long = 0;
      end else if (r < 75) begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255, 0)));
      end else if (r < 85) begin
        repeat ($urandom_range(3, 1)) send_read();
      end else if (r < 90) begin
        send_none();
      end else if (r < 95) begin
        send_release();
      end else begin
        random_frame(0, 0);
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_queue.sv
rtl/dfr_back.sv
rtl/delimited_frame_receiver.sv
tb/delimited_frame_receiver_test.sv
